FILE: src/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

	localparam int BASE_W  = 32;
	localparam int DATA_W  = 32;
	localparam int INDEX_W = 2;
	localparam int CNT_W   = $clog2(BASE_W);

	localparam logic [INDEX_W-1:0] REG_MODULUS  = INDEX_W'(0);
	localparam logic [INDEX_W-1:0] REG_EXPONENT = INDEX_W'(1);

endpackage

`default_nettype wire

FILE: src/mexp_mulmod.sv
`default_nettype none

module mexp_mulmod #(
	parameter int MOD_BITS = 31
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [MOD_BITS-1:0]               op_a,
	input  wire logic [mexp_pkg::BASE_W-1:0]       op_b,
	input  wire logic [MOD_BITS-1:0]               op_m,
	output logic                                   done,
	output logic [MOD_BITS-1:0]                    prod
);

	localparam int T_W = MOD_BITS + 2;

	logic                          busy_q;
	logic                          done_q;
	logic [mexp_pkg::CNT_W-1:0]    cnt_q;
	logic [MOD_BITS-1:0]           r_q;
	logic [MOD_BITS-1:0]           a_q;
	logic [MOD_BITS-1:0]           m_q;
	logic [mexp_pkg::BASE_W-1:0]   b_q;

	logic [T_W-1:0] m_ext;
	logic [T_W-1:0] t_sum;
	logic [T_W-1:0] t_one;
	logic [T_W-1:0] t_two;

	always_comb begin
		m_ext = T_W'(m_q);
		t_sum = {1'b0, r_q, 1'b0} + (b_q[mexp_pkg::BASE_W-1] ? T_W'(a_q) : '0);
		t_one = (t_sum >= m_ext) ? t_sum - m_ext : t_sum;
		t_two = (t_one >= m_ext) ? t_one - m_ext : t_one;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= mexp_pkg::CNT_W'(mexp_pkg::BASE_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			a_q <= op_a;
			b_q <= op_b;
			m_q <= op_m;
		end else if (busy_q) begin
			r_q <= t_two[MOD_BITS-1:0];
			b_q <= {b_q[mexp_pkg::BASE_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = r_q;

endmodule

`default_nettype wire

FILE: src/modular_exponentiation_core.sv
`default_nettype none

// channel   direction  handshake                 payload
// cmd       in         start & !busy             base_value
// result    out        done (one cycle)          power_result
// cfg       in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// Every modular multiply runs in the single shared shift-add-reduce unit.
// An item runs one reduction of the base, then S squarings (bit length of the
// exponent minus one) and P multiplies (set bits). A zero exponent or zero
// modulus skips the multiplier. Reset: idle, modulus 1, exponent 1.
// The result cannot be stalled; busy stays high until the done cycle ends.

module modular_exponentiation_core #(
	parameter int MOD_BITS = 31,
	parameter int EXP_BITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [mexp_pkg::BASE_W-1:0]        base_value,
	output logic                                    done,
	output logic [MOD_BITS-1:0]                     power_result,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [mexp_pkg::INDEX_W-1:0]       cfg_index,
	input  wire logic [mexp_pkg::DATA_W-1:0]        cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RED  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_SQR  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]                    state_q;
	logic                          go_q;
	logic [MOD_BITS-1:0]           modulus_q;
	logic [EXP_BITS-1:0]           exponent_q;
	logic [EXP_BITS-1:0]           erem_q;
	logic [MOD_BITS-1:0]           acc_q;
	logic [MOD_BITS-1:0]           pw_q;
	logic [mexp_pkg::BASE_W-1:0]   base_q;

	logic [MOD_BITS-1:0]           mm_a;
	logic [mexp_pkg::BASE_W-1:0]   mm_b;
	logic                          mm_done;
	logic [MOD_BITS-1:0]           mm_prod;
	logic [EXP_BITS-1:0]           erem_next;

	assign erem_next = erem_q >> 1;

	always_comb begin
		case (state_q)
			ST_RED: begin
				mm_a = MOD_BITS'(1);
				mm_b = base_q;
			end
			ST_MUL: begin
				mm_a = acc_q;
				mm_b = mexp_pkg::BASE_W'(pw_q);
			end
			default: begin
				mm_a = pw_q;
				mm_b = mexp_pkg::BASE_W'(pw_q);
			end
		endcase
	end

	mexp_mulmod #(
		.MOD_BITS(MOD_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q),
		.op_a   (mm_a),
		.op_b   (mm_b),
		.op_m   (modulus_q),
		.done   (mm_done),
		.prod   (mm_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MOD_BITS'(1);
			exponent_q <= EXP_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mexp_pkg::REG_MODULUS:  modulus_q  <= cfg_data[MOD_BITS-1:0];
				mexp_pkg::REG_EXPONENT: exponent_q <= cfg_data[EXP_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q    <= 1'b0;
		end else begin
			go_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (exponent_q == '0 || modulus_q == '0) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_RED;
							go_q    <= 1'b1;
						end
					end
				end
				ST_RED: begin
					if (mm_done) begin
						state_q <= erem_q[0] ? ST_MUL : ST_SQR;
						go_q    <= 1'b1;
					end
				end
				ST_MUL: begin
					if (mm_done) begin
						if (erem_next == '0) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_SQR;
							go_q    <= 1'b1;
						end
					end
				end
				ST_SQR: begin
					if (mm_done) begin
						state_q <= erem_next[0] ? ST_MUL : ST_SQR;
						go_q    <= 1'b1;
					end
				end
				ST_OUT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					base_q <= base_value;
					erem_q <= exponent_q;
					if (exponent_q == '0) begin
						acc_q <= MOD_BITS'(1);
					end else if (modulus_q == MOD_BITS'(1) || modulus_q == '0) begin
						acc_q <= '0;
					end else begin
						acc_q <= MOD_BITS'(1);
					end
				end
			end
			ST_RED: begin
				if (mm_done) begin
					pw_q <= mm_prod;
				end
			end
			ST_MUL: begin
				if (mm_done) begin
					acc_q <= mm_prod;
				end
			end
			ST_SQR: begin
				if (mm_done) begin
					pw_q   <= mm_prod;
					erem_q <= erem_next;
				end
			end
			default: ;
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = (state_q == ST_OUT);
	assign power_result = acc_q;
	assign cfg_ready    = 1'b1;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && exponent_q != '0 && modulus_q != '0 |-> power_result < modulus_q)
		else $error("result not reduced by modulus");

	a_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE || state_q == ST_OUT |-> !go_q)
		else $error("multiplier launched outside a work state");
`endif

endmodule

`default_nettype wire

FILE: sim/mexp_result_checker.sv
`default_nettype none

module mexp_result_checker #(
	parameter int MOD_BITS = 31,
	parameter int EXP_BITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic                               busy,
	input  wire logic [mexp_pkg::BASE_W-1:0]        base_value,
	input  wire logic                               done,
	input  wire logic [MOD_BITS-1:0]                power_result,
	input  wire logic                               cfg_valid,
	input  wire logic                               cfg_ready,
	input  wire logic [mexp_pkg::INDEX_W-1:0]       cfg_index,
	input  wire logic [mexp_pkg::DATA_W-1:0]        cfg_data,
	output int                                      fail_count,
	output int                                      pending,
	output int                                      checked
);

	timeunit 1ns;
	timeprecision 1ps;

	logic [MOD_BITS-1:0] modulus_reg;
	logic [EXP_BITS-1:0] exponent_reg;
	logic [MOD_BITS-1:0] expected_powers[$];
	logic [MOD_BITS-1:0] oldest_power;
	int                  errors = 0;
	int                  results_seen = 0;

	function automatic logic [MOD_BITS-1:0] predict_power(
		input logic [mexp_pkg::BASE_W-1:0] base,
		input logic [EXP_BITS-1:0]         expo,
		input logic [MOD_BITS-1:0]         modv
	);
		longint unsigned acc;
		longint unsigned pw;
		longint unsigned mm;
		if (expo == '0) begin
			return MOD_BITS'(1);
		end
		if (modv == '0) begin
			return '0;
		end
		mm  = longint'(modv);
		pw  = longint'(base) % mm;
		acc = 64'd1 % mm;
		for (int i = 0; i < EXP_BITS; i++) begin
			if (expo[i]) begin
				acc = (acc * pw) % mm;
			end
			pw = (pw * pw) % mm;
		end
		return MOD_BITS'(acc);
	endfunction

	assign fail_count = errors;
	assign pending    = expected_powers.size();
	assign checked    = results_seen;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_reg  <= MOD_BITS'(1);
			exponent_reg <= EXP_BITS'(1);
			expected_powers.delete();
		end else begin
			if (done) begin
				if (expected_powers.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word: expected none, actual %0d",
						$time, power_result);
				end else begin
					oldest_power = expected_powers.pop_front();
					results_seen++;
					if (power_result !== oldest_power) begin
						errors++;
						$display("%0t: power_result mismatch: expected %0d, actual %0d",
							$time, oldest_power, power_result);
					end
				end
			end
			if (start && !busy) begin
				expected_powers = {expected_powers, predict_power(base_value,
					exponent_reg, modulus_reg)};
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mexp_pkg::REG_MODULUS) begin
					modulus_reg <= cfg_data[MOD_BITS-1:0];
				end else if (cfg_index == mexp_pkg::REG_EXPONENT) begin
					exponent_reg <= cfg_data[EXP_BITS-1:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: sim/tb_modular_exponentiation_core.sv
`default_nettype none

module tb_modular_exponentiation_core;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MOD_BITS    = 31;
	localparam int EXP_BITS    = 32;
	localparam int STALL_LIMIT = 20000;
	localparam int RAND_PHASES = 7;
	localparam int PHASE_ITEMS = 18;

	localparam logic [mexp_pkg::INDEX_W-1:0] REG_SPARE_A = mexp_pkg::INDEX_W'(2);
	localparam logic [mexp_pkg::INDEX_W-1:0] REG_SPARE_B = mexp_pkg::INDEX_W'(3);

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             start;
	logic                             busy;
	logic [mexp_pkg::BASE_W-1:0]      base_value;
	logic                             done;
	logic [MOD_BITS-1:0]              power_result;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [mexp_pkg::INDEX_W-1:0]     cfg_index;
	logic [mexp_pkg::DATA_W-1:0]      cfg_data;

	int                               fail_count;
	int                               pending;
	int                               checked;
	int                               stall_cycles = 0;
	int                               register_writes;
	int                               settings_used;
	bit                               idle_enable;
	logic [MOD_BITS-1:0]              cur_mod;
	logic [MOD_BITS-1:0]              rand_mod;
	logic [EXP_BITS-1:0]              rand_exp;
	logic [mexp_pkg::BASE_W-1:0]      rand_base;

	modular_exponentiation_core #(
		.MOD_BITS (MOD_BITS),
		.EXP_BITS (EXP_BITS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.base_value   (base_value),
		.done         (done),
		.power_result (power_result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	mexp_result_checker #(
		.MOD_BITS (MOD_BITS),
		.EXP_BITS (EXP_BITS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.base_value   (base_value),
		.done         (done),
		.power_result (power_result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("** modular_exponentiation_core: FAILED **");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic write_register(input logic [mexp_pkg::INDEX_W-1:0] idx,
		input logic [mexp_pkg::DATA_W-1:0] data);
		while (idle_enable && $urandom_range(99) < 29) begin
			@(negedge clk);
		end
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		register_writes++;
		if (idx == mexp_pkg::REG_MODULUS) begin
			cur_mod = data[MOD_BITS-1:0];
		end
	endtask

	task automatic send_base(input logic [mexp_pkg::BASE_W-1:0] b);
		while (idle_enable && $urandom_range(99) < 29) begin
			start = 1'b0;
			@(negedge clk);
		end
		start      = 1'b1;
		base_value = b;
		do @(posedge clk); while (!(start && !busy));
		@(negedge clk);
	endtask

	// drop start and hold until every expected word has come back
	task automatic drain;
		start = 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		settings_used++;
	endtask

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		base_value      = '0;
		cfg_valid       = 1'b0;
		cfg_index       = mexp_pkg::REG_MODULUS;
		cfg_data        = '0;
		idle_enable     = 1'b1;
		register_writes = 0;
		settings_used   = 0;
		cur_mod         = MOD_BITS'(1);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_base(32'hFFFF_FFFF);
		send_base(32'd7);
		drain();

		write_register(mexp_pkg::REG_MODULUS, 32'h7FFF_FFFF);
		write_register(mexp_pkg::REG_EXPONENT, 32'hFFFF_FFFF);
		send_base(32'h0000_0000);
		send_base(32'h0000_0001);
		send_base(32'hFFFF_FFFF);
		send_base(32'h7FFF_FFFE);
		send_base(32'h8000_0000);
		send_base(32'h7FFF_FFFF);
		drain();

		write_register(mexp_pkg::REG_EXPONENT, 32'h0000_0000);
		send_base(32'h0000_0000);
		send_base(32'd12345);
		drain();

		write_register(mexp_pkg::REG_MODULUS, 32'd1);
		send_base(32'd99);
		drain();

		write_register(mexp_pkg::REG_EXPONENT, 32'd5);
		send_base(32'hFFFF_FFFF);
		drain();

		write_register(mexp_pkg::REG_MODULUS, 32'd2);
		write_register(mexp_pkg::REG_EXPONENT, 32'd1);
		send_base(32'd3);
		send_base(32'hFFFF_FFFE);
		drain();

		write_register(REG_SPARE_A, 32'hFFFF_FFFF);
		write_register(REG_SPARE_B, 32'h5555_5555);
		send_base(32'd3);
		drain();

		write_register(mexp_pkg::REG_MODULUS, 32'd1000003);
		write_register(mexp_pkg::REG_EXPONENT, 32'd65537);
		send_base(32'd2);
		send_base(32'hDEAD_BEEF);
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			idle_enable = (p != 2);
			case ($urandom_range(5))
				0:       rand_mod = MOD_BITS'(1);
				1:       rand_mod = MOD_BITS'(2);
				2:       rand_mod = MOD_BITS'($urandom_range(200, 3));
				3:       rand_mod = MOD_BITS'(32'h7FFF_FFFF);
				default: rand_mod = MOD_BITS'($urandom_range(32'h7FFF_FFFF, 1));
			endcase
			case ($urandom_range(6))
				0:       rand_exp = '0;
				1:       rand_exp = EXP_BITS'(1);
				2:       rand_exp = '1;
				3:       rand_exp = EXP_BITS'($urandom_range(16, 2));
				4:       rand_exp = 32'h8000_0000;
				default: rand_exp = $urandom();
			endcase
			if ($urandom_range(1)) begin
				write_register(mexp_pkg::REG_MODULUS, 32'(rand_mod));
				write_register(mexp_pkg::REG_EXPONENT, rand_exp);
			end else begin
				write_register(mexp_pkg::REG_EXPONENT, rand_exp);
				write_register(mexp_pkg::REG_MODULUS, 32'(rand_mod));
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				case ($urandom_range(5))
					0:       rand_base = 32'($urandom_range(15));
					1:       rand_base = 32'hFFFF_FFFF - 32'($urandom_range(15));
					2:       rand_base = 32'(cur_mod) + 32'($urandom_range(3)) - 32'd1;
					3:       rand_base = 32'($urandom_range(32'(cur_mod) - 1, 0));
					default: rand_base = $urandom();
				endcase
				send_base(rand_base);
			end
			drain();
		end

		repeat (50) @(posedge clk);
		$display("%0d base words checked across %0d register settings, %0d register writes",
			checked, settings_used, register_writes);
		$display("settings included modulus 1, 2 and 2^31-1 and exponents 0, 1 and 2^32-1");
		if (fail_count == 0 && pending == 0) begin
			$display("** modular_exponentiation_core: PASSED **");
		end else begin
			$display("** modular_exponentiation_core: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
src/mexp_pkg.sv
src/mexp_mulmod.sv
src/modular_exponentiation_core.sv
sim/mexp_result_checker.sv
sim/tb_modular_exponentiation_core.sv
